>>> hw/rtl/tcsw_pkg.sv
`timescale 1ns / 1ps

package tcsw_pkg;

    // Width of one stored cell: character in the low byte, attribute in the high byte.
    localparam int CELL_W = 16;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // Attribute after reset and the byte mask of the data path.
    localparam logic [7:0] ATTR_RESET = 8'h09;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    // Request kinds.
    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_WRAP,
        S_LCLR,
        S_SCAN,
        S_BSW,
        S_DONE
    } tcsw_state_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_position;
        logic [6:0]  top_line;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } tcsw_result_t;

endpackage

>>> hw/rtl/tcsw_in_if.sv
`timescale 1ns / 1ps

interface tcsw_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, output action, output char_code, output read_row,
                    output read_col, input ready);
    modport sink (input valid, input action, input char_code, input read_row,
                  input read_col, output ready);
endinterface

>>> hw/rtl/tcsw_out_if.sv
`timescale 1ns / 1ps

interface tcsw_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_position;
    logic [6:0]  top_line;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;

    modport source (output valid, output cursor_row, output cursor_col,
                    output cursor_position, output top_line, output scrolled,
                    output cell_char, output cell_attr, input ready);
    modport sink (input valid, input cursor_row, input cursor_col,
                  input cursor_position, input top_line, input scrolled,
                  input cell_char, input cell_attr, output ready);
endinterface

>>> hw/rtl/tcsw_cell_ram.sv
`timescale 1ns / 1ps

module tcsw_cell_ram
    import tcsw_pkg::*;
#(
    parameter int ADDR_W = 14,
    parameter int DEPTH  = 16384
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [CELL_W-1:0] wdata,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    // Single port, read before write.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tcsw_ring_unit.sv
`timescale 1ns / 1ps

module tcsw_ring_unit #(
    parameter int RING_LINES = 128,
    parameter int ROWS       = 25
)
(
    input  logic [$clog2(RING_LINES)-1:0] base,
    input  logic [$clog2(ROWS)-1:0]       offset,
    output logic [$clog2(RING_LINES)-1:0] line
);

    localparam int LINE_W = $clog2(RING_LINES);
    localparam int SUM_W  = $clog2(RING_LINES + ROWS);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] step1;
    logic [SUM_W-1:0] step2;

    // The sum stays below three ring lengths, so two conditional subtracts reduce it.
    always_comb
    begin
        sum   = SUM_W'(base) + SUM_W'(offset);
        step1 = (sum >= SUM_W'(RING_LINES)) ? sum - SUM_W'(RING_LINES) : sum;
        step2 = (step1 >= SUM_W'(RING_LINES)) ? step1 - SUM_W'(RING_LINES) : step1;
        line  = LINE_W'(step2);
    end

endmodule

>>> hw/rtl/tcsw_ctrl.sv
`timescale 1ns / 1ps

module tcsw_ctrl
    import tcsw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int RING_LINES = 128,
    parameter int ADDR_W     = 14,
    parameter int DEPTH      = 16384
)
(
    input  logic              clk,
    input  logic              rst_n,
    tcsw_in_if.sink           in_ch,
    input  logic [7:0]        attr,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [CELL_W-1:0] ram_wdata,
    input  logic [CELL_W-1:0] ram_rdata,
    output tcsw_result_t      res,
    output logic              res_valid,
    input  logic              res_ready
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int LINE_W = $clog2(RING_LINES);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    tcsw_state_t state_reg, state_next;

    logic              act_reg, act_next;
    logic [7:0]        ch_reg, ch_next;
    logic [4:0]        rrow_reg, rrow_next;
    logic [6:0]        rcol_reg, rcol_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] top_reg, top_next;
    logic              nl_reg, nl_next;
    logic              scr_reg, scr_next;
    logic [7:0]        cchar_reg, cchar_next;
    logic [7:0]        cattr_reg, cattr_next;
    logic [COL_W-1:0]  scan_col_reg, scan_col_next;
    logic              pend_reg, pend_next;
    logic [COL_W-1:0]  pend_col_reg, pend_col_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [ROW_W-1:0]  ring_off;
    logic [LINE_W-1:0] ring_line;
    logic              cell_nonblank;

    tcsw_ring_unit #(
        .RING_LINES (RING_LINES),
        .ROWS       (ROWS)
    ) u_ring (
        .base   (top_reg),
        .offset (ring_off),
        .line   (ring_line)
    );

    assign cell_nonblank = (ram_rdata[7:0] != CH_NUL) && (ram_rdata[7:0] != CH_SPACE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            act_reg      <= ACT_PUT;
            ch_reg       <= '0;
            rrow_reg     <= '0;
            rcol_reg     <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            nl_reg       <= 1'b0;
            scr_reg      <= 1'b0;
            cchar_reg    <= '0;
            cattr_reg    <= '0;
            scan_col_reg <= '0;
            pend_reg     <= 1'b0;
            pend_col_reg <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            act_reg      <= act_next;
            ch_reg       <= ch_next;
            rrow_reg     <= rrow_next;
            rcol_reg     <= rcol_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            top_reg      <= top_next;
            nl_reg       <= nl_next;
            scr_reg      <= scr_next;
            cchar_reg    <= cchar_next;
            cattr_reg    <= cattr_next;
            scan_col_reg <= scan_col_next;
            pend_reg     <= pend_next;
            pend_col_reg <= pend_col_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        ch_next       = ch_reg;
        rrow_next     = rrow_reg;
        rcol_next     = rcol_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        top_next      = top_reg;
        nl_next       = nl_reg;
        scr_next      = scr_reg;
        cchar_next    = cchar_reg;
        cattr_next    = cattr_reg;
        scan_col_next = scan_col_reg;
        pend_next     = pend_reg;
        pend_col_next = pend_col_reg;
        clr_cnt_next  = clr_cnt_reg;

        in_ch.ready = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = {ring_line, col_reg};
        ram_wdata   = {attr, CH_SPACE};
        ring_off    = row_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    act_next   = in_ch.action;
                    ch_next    = in_ch.char_code;
                    rrow_next  = in_ch.read_row;
                    rcol_next  = in_ch.read_col;
                    nl_next    = 1'b0;
                    scr_next   = 1'b0;
                    cchar_next = '0;
                    cattr_next = '0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (act_reg == ACT_READ)
                begin
                    ring_off = ROW_W'(rrow_reg);
                    if ((rrow_reg < ROWS) && (rcol_reg < COLUMNS))
                    begin
                        ram_addr   = {ring_line, COL_W'(rcol_reg)};
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_WRAP;
                    unique case (ch_reg)
                        CH_NEWLINE:
                        begin
                            col_next = '0;
                            nl_next  = 1'b1;
                        end
                        CH_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                                ram_we   = 1'b1;
                                ram_addr = {ring_line, col_reg - 1'b1};
                            end
                            else if (row_reg != '0)
                            begin
                                row_next      = row_reg - 1'b1;
                                scan_col_next = LAST_COL;
                                pend_next     = 1'b0;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        default:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {attr, ch_reg};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                nl_next  = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                cchar_next = ram_rdata[7:0];
                cattr_next = ram_rdata[15:8];
                state_next = S_DONE;
            end

            S_WRAP:
            begin
                // Shared unit forms the advanced top line when scrolling.
                ring_off   = ROW_W'(1);
                state_next = S_DONE;
                if (nl_reg)
                begin
                    if (row_reg == LAST_ROW)
                    begin
                        top_next      = ring_line;
                        scr_next      = 1'b1;
                        scan_col_next = '0;
                        state_next    = S_LCLR;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end

            S_LCLR:
            begin
                ring_off      = LAST_ROW;
                ram_we        = 1'b1;
                ram_addr      = {ring_line, scan_col_reg};
                ram_wdata     = '0;
                scan_col_next = scan_col_reg + 1'b1;
                if (scan_col_reg == LAST_COL)
                begin
                    state_next = S_DONE;
                end
            end

            S_SCAN:
            begin
                // One read issued per cycle; the data of the previous read is checked.
                if (pend_reg && cell_nonblank)
                begin
                    col_next   = (pend_col_reg == LAST_COL) ? LAST_COL : pend_col_reg + 1'b1;
                    state_next = S_BSW;
                end
                else if (pend_reg && (pend_col_reg == '0))
                begin
                    col_next   = '0;
                    state_next = S_BSW;
                end
                else
                begin
                    ram_addr      = {ring_line, scan_col_reg};
                    pend_next     = 1'b1;
                    pend_col_next = scan_col_reg;
                    scan_col_next = scan_col_reg - 1'b1;
                end
            end

            S_BSW:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.cursor_row      = 5'(row_reg);
        res.cursor_col      = 7'(col_reg);
        res.cursor_position = 11'(row_reg * COLUMNS + col_reg);
        res.top_line        = 7'(top_reg);
        res.scrolled        = scr_reg;
        res.cell_char       = cchar_reg;
        res.cell_attr       = cattr_reg;
    end

    // No memory write may happen while a request can be taken.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("cell write while idle");

    // An accepted request always goes to the execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    // The cursor row never leaves the screen.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= LAST_ROW)
        else $error("cursor row out of range");

    // A scroll leaves the cursor on the bottom row.
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.scrolled) |-> (row_reg == LAST_ROW))
        else $error("scroll with cursor off the bottom row");

    // The scan issues reads one column below the column being checked.
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && pend_reg && (pend_col_reg != '0))
        |-> (scan_col_reg == COL_W'(pend_col_reg - 1'b1)))
        else $error("backspace scan out of order");

endmodule

>>> hw/rtl/text_console_scrollback_writer_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Contents
// in_ch     in   valid/ready            action, char_code, read_row, read_col
// out_ch    out  valid/ready            cursor, position, top line, scroll flag, cell
// cfg       in   cfg_we, no wait        cfg_wdata: attribute byte for written cells
//
// After reset the block sweeps all RING_LINES * 2**clog2(COLUMNS) cells of the cell memory
// (16384 at the defaults) to zero, one cell per cycle, with in_ch.ready low.
// A read passes through the execute and read-wait states, a read out of range through the
// execute state only, a printable character or a newline without scroll through the execute
// and wrap states; a scroll then clears the new bottom line; a backspace at column 0 below
// the top row scans the row above from the right. The next request can be taken as soon as
// the result enters the output register, even while out_ch is stalled.

module text_console_scrollback_writer_unit
    import tcsw_pkg::*;
#(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int RING_LINES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    tcsw_in_if.sink    in_ch,
    tcsw_out_if.source out_ch,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    // Cells are addressed as {ring line, column}, so no multiply sits in the address path.
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int LINE_W = $clog2(RING_LINES);
    localparam int ADDR_W = LINE_W + COL_W;
    localparam int DEPTH  = RING_LINES << COL_W;

    logic [7:0]        attr_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;
    tcsw_result_t      res;
    logic              res_valid;
    logic              res_ready;
    tcsw_result_t      out_res_reg;
    logic              out_valid_reg;

    // The user must write the attribute register only while no request is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_wdata & BYTE_MASK;
        end
    end

    tcsw_cell_ram #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    tcsw_ctrl #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .RING_LINES (RING_LINES),
        .ADDR_W     (ADDR_W),
        .DEPTH      (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .attr      (attr_reg),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // Output register: the sequencer hands over its result whenever the slot is free or being emptied.
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.cursor_row      = out_res_reg.cursor_row;
    assign out_ch.cursor_col      = out_res_reg.cursor_col;
    assign out_ch.cursor_position = out_res_reg.cursor_position;
    assign out_ch.top_line        = out_res_reg.top_line;
    assign out_ch.scrolled        = out_res_reg.scrolled;
    assign out_ch.cell_char       = out_res_reg.cell_char;
    assign out_ch.cell_attr       = out_res_reg.cell_attr;

endmodule
